// ===== hdl/mlfq_pkg.sv =====
// ============================================================================
// mlfq_pkg
// Shared types, constants and fixed-point helpers of the priority tracker.
// ============================================================================
package mlfq_pkg;

    localparam int NUM_SLOTS = 64;
    localparam int SLOT_W    = 6;
    localparam int FRAC_BITS = 14;
    localparam int FP_ONE    = 1 << FRAC_BITS;
    localparam int PRIO_MAX  = 63;
    localparam int LOAD_W    = 21;
    localparam int LOAD_A    = (59 * FP_ONE) / 60;
    localparam int LOAD_B    = FP_ONE / 60;
    localparam int COEF_W    = FRAC_BITS;
    localparam int NUM_W     = LOAD_W + 1 + FRAC_BITS;
    localparam int DEN_W     = LOAD_W + 2;

    localparam logic [2:0] FN_TICK    = 3'd0;
    localparam logic [2:0] FN_SECOND  = 3'd1;
    localparam logic [2:0] FN_REFRESH = 3'd2;
    localparam logic [2:0] FN_NICE    = 3'd3;
    localparam logic [2:0] FN_CREATE  = 3'd4;
    localparam logic [2:0] FN_REMOVE  = 3'd5;
    localparam logic [2:0] FN_QUERY   = 3'd6;
    localparam logic [2:0] FN_SPARE   = 3'd7;

    typedef struct packed {
        logic               valid;
        logic signed [5:0]  nice;
        logic signed [31:0] rcpu;
        logic [5:0]         prio;
    } slot_entry_t;

    // round(PRIO_MAX - rcpu/4 - 2*nice) clamped to 0..PRIO_MAX
    function automatic logic [5:0] calc_prio(logic signed [31:0] rcpu,
                                             logic signed [5:0] nice);
        logic signed [35:0] q4;
        logic signed [35:0] x;
        logic [35:0]        r;
        logic [5:0]         p;
        q4 = ($signed(36'(rcpu)) + (rcpu[31] ? 36'sd3 : 36'sd0)) >>> 2;
        x  = $signed(36'(PRIO_MAX * FP_ONE)) - q4
             - ($signed(36'(nice)) <<< (FRAC_BITS + 1));
        r  = (36'(x) + 36'(FP_ONE / 2)) >> FRAC_BITS;
        if (x[35])
            p = 6'd0;
        else if (r > 36'(PRIO_MAX))
            p = 6'(PRIO_MAX);
        else
            p = r[5:0];
        return p;
    endfunction

endpackage

// ===== hdl/mlfq_priority_tracker.sv =====
// ============================================================================
// mlfq_priority_tracker
// Thread slot table with load average, recent cpu and priority upkeep.
// ============================================================================
// usage
//   input channel: in_valid / in_stall with func, slot, running_slot,
//   ready_count and nice_value; a word is taken when in_valid is high and
//   in_stall is low. in_stall is high while an operation is in progress.
//   output channel: out_valid / out_stall; every input word yields exactly
//   one result word describing the addressed slot after the operation.
//   cfg_wr_en / cfg_wr_data write idle_slot; the user writes it only while
//   idle, which the block itself does not enforce.
// steps, from the accepted word to the result in the output register
//   query, remove: slot read; tick, set nice, create: read, write, slot read
//   priority refresh: a read and a priority write per slot, then slot read
//   second update: load average and the 14-bit coefficient divide, then a
//   read-multiply-write pass per slot, then slot read
//   next word taken once the result is loaded; memory reads are registered
// reset
//   all slots dead, load average zero, idle_slot zero, output empty
// stall
//   the result sits in the output register; the next word is accepted and
//   processed up to its result, which then waits until the register frees
// ============================================================================
module mlfq_priority_tracker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [5:0]        cfg_wr_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [2:0]        func,
    input  logic [5:0]        slot,
    input  logic [5:0]        running_slot,
    input  logic [6:0]        ready_count,
    input  logic signed [5:0] nice_value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              slot_valid,
    output logic [5:0]        slot_priority,
    output logic signed [5:0] slot_nice,
    output logic signed [24:0] recent_cpu_x100,
    output logic [12:0]       load_avg_x100
);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_TICK   = 4'd1;
    localparam logic [3:0] S_LOAD   = 4'd2;
    localparam logic [3:0] S_DIV    = 4'd3;
    localparam logic [3:0] S_SW_RD  = 4'd4;
    localparam logic [3:0] S_SW_OP  = 4'd5;
    localparam logic [3:0] S_SW_WR  = 4'd6;
    localparam logic [3:0] S_SETN   = 4'd7;
    localparam logic [3:0] S_CREATE = 4'd8;
    localparam logic [3:0] S_REP_RD = 4'd9;
    localparam logic [3:0] S_REP    = 4'd10;

    logic [3:0]                       state_reg, state_next;
    logic [2:0]                       func_reg;
    logic [5:0]                       slot_reg;
    logic [5:0]                       run_reg;
    logic [6:0]                       ready_reg;
    logic signed [5:0]                nice_in_reg;
    logic [5:0]                       idle_slot_reg;
    logic [mlfq_pkg::LOAD_W-1:0]      load_reg;
    logic [mlfq_pkg::COEF_W-1:0]      coef_reg;
    logic [5:0]                       idx_reg;
    logic signed [46:0]               prod_reg;
    logic                             out_valid_reg;

    // slot memory port
    logic                             rd_en;
    logic [5:0]                       rd_addr;
    mlfq_pkg::slot_entry_t            rd_entry;
    logic                             wr_en;
    logic [5:0]                       wr_addr;
    mlfq_pkg::slot_entry_t            wr_entry;

    // load average / divider
    logic [34:0]                      la_prod;
    logic [21:0]                      la_sum;
    logic [mlfq_pkg::LOAD_W-1:0]      load_next;
    logic [21:0]                      two_load;
    logic                             div_start;
    logic                             div_done;
    logic [mlfq_pkg::COEF_W-1:0]      div_quot;

    // per-slot arithmetic
    logic                             entry_live;
    logic [5:0]                       entry_addr;
    logic signed [32:0]               tick_sum;
    logic signed [31:0]               tick_rcpu;
    logic signed [46:0]               dec_adj;
    logic signed [33:0]               dec_sum;
    logic signed [31:0]               dec_rcpu;
    logic signed [5:0]                nice_clamped;
    logic                             sweep_last;

    // result formatting
    logic signed [38:0]               rc100;
    logic [38:0]                      rc100_mag;
    logic [24:0]                      rc_round;
    logic [27:0]                      ld100;
    logic [27:0]                      ld_round;

    mlfq_slot_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry)
    );

    mlfq_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({two_load, mlfq_pkg::FRAC_BITS'(0)}),
        .den   (mlfq_pkg::DEN_W'(two_load) + mlfq_pkg::DEN_W'(mlfq_pkg::FP_ONE)),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;

    // load = 59/60 load + 1/60 ready, never negative
    assign la_prod  = 35'(mlfq_pkg::LOAD_A) * 35'(load_reg);
    assign la_sum   = 22'(la_prod >> mlfq_pkg::FRAC_BITS)
                    + 22'(mlfq_pkg::LOAD_B) * 22'(ready_reg);
    assign load_next = la_sum[21] ? {mlfq_pkg::LOAD_W{1'b1}} : la_sum[20:0];
    // divider starts from the new load average while it is being stored
    assign two_load  = {load_next, 1'b0};
    assign div_start = state_reg == S_LOAD;

    // which slot the pending read data belongs to
    always_comb
    begin
        unique case (state_reg)
            S_TICK, S_CREATE:  entry_addr = run_reg;
            S_SETN, S_REP:     entry_addr = slot_reg;
            default:           entry_addr = idx_reg;
        endcase
    end
    assign entry_live = rd_entry.valid && entry_addr != idle_slot_reg;
    assign sweep_last = idx_reg == 6'(mlfq_pkg::NUM_SLOTS - 1);

    // tick: saturating add of one
    assign tick_sum  = 33'(rd_entry.rcpu) + 33'(mlfq_pkg::FP_ONE);
    assign tick_rcpu = (tick_sum > 33'sh07FFFFFFF) ? 32'sh7FFFFFFF : tick_sum[31:0];

    // decay: coef * rcpu / one (toward zero) + nice
    assign dec_adj = prod_reg + (prod_reg[46] ? 47'(mlfq_pkg::FP_ONE - 1) : 47'sd0);
    assign dec_sum = 34'(dec_adj >>> mlfq_pkg::FRAC_BITS)
                   + ($signed(34'(rd_entry.nice)) <<< mlfq_pkg::FRAC_BITS);
    always_comb
    begin
        if (dec_sum > 34'sh07FFFFFFF)
            dec_rcpu = 32'sh7FFFFFFF;
        else if (dec_sum < -34'sh080000000)
            dec_rcpu = -32'sh80000000;
        else
            dec_rcpu = dec_sum[31:0];
    end

    always_comb
    begin
        if (nice_in_reg < -6'sd20)
            nice_clamped = -6'sd20;
        else if (nice_in_reg > 6'sd20)
            nice_clamped = 6'sd20;
        else
            nice_clamped = nice_in_reg;
    end

    // result rounding, half away from zero
    assign rc100     = $signed(39'(rd_entry.rcpu)) * 39'sd100;
    assign rc100_mag = rc100[38] ? 39'(-rc100) : 39'(rc100);
    assign rc_round  = 25'((rc100_mag + 39'(mlfq_pkg::FP_ONE / 2)) >> mlfq_pkg::FRAC_BITS);
    assign ld100     = 28'(load_reg) * 28'd100;
    assign ld_round  = (ld100 + 28'(mlfq_pkg::FP_ONE / 2)) >> mlfq_pkg::FRAC_BITS;

    // memory port control and next state
    always_comb
    begin
        state_next = state_reg;
        rd_en      = 1'b0;
        rd_addr    = slot_reg;
        wr_en      = 1'b0;
        wr_addr    = entry_addr;
        wr_entry   = rd_entry;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (func)
                        mlfq_pkg::FN_TICK:
                        begin
                            rd_en = 1'b1;
                            rd_addr = running_slot;
                            state_next = S_TICK;
                        end
                        mlfq_pkg::FN_SECOND:  state_next = S_LOAD;
                        mlfq_pkg::FN_REFRESH: state_next = S_SW_RD;
                        mlfq_pkg::FN_NICE:
                        begin
                            rd_en = 1'b1;
                            rd_addr = slot;
                            state_next = S_SETN;
                        end
                        mlfq_pkg::FN_CREATE:
                        begin
                            rd_en = 1'b1;
                            rd_addr = running_slot;
                            state_next = S_CREATE;
                        end
                        mlfq_pkg::FN_REMOVE:
                        begin
                            wr_en = 1'b1;
                            wr_addr = slot;
                            wr_entry.valid = 1'b0;
                            state_next = S_REP_RD;
                        end
                        default: state_next = S_REP_RD;
                    endcase
                end
            end
            S_TICK:
            begin
                wr_en = entry_live;
                wr_entry.rcpu = tick_rcpu;
                state_next = S_REP_RD;
            end
            S_LOAD:   state_next = S_DIV;
            S_DIV:
            begin
                if (div_done)
                    state_next = S_SW_RD;
            end
            S_SW_RD:
            begin
                rd_en = 1'b1;
                rd_addr = idx_reg;
                state_next = S_SW_OP;
            end
            S_SW_OP:
            begin
                if (func_reg == mlfq_pkg::FN_SECOND)
                    state_next = S_SW_WR;
                else
                begin
                    wr_en = entry_live;
                    wr_entry.prio = mlfq_pkg::calc_prio(rd_entry.rcpu, rd_entry.nice);
                    state_next = sweep_last ? S_REP_RD : S_SW_RD;
                end
            end
            S_SW_WR:
            begin
                wr_en = entry_live;
                wr_entry.rcpu = dec_rcpu;
                state_next = sweep_last ? S_REP_RD : S_SW_RD;
            end
            S_SETN:
            begin
                wr_en = entry_live;
                wr_entry.nice = nice_clamped;
                wr_entry.prio = mlfq_pkg::calc_prio(rd_entry.rcpu, nice_clamped);
                state_next = S_REP_RD;
            end
            S_CREATE:
            begin
                wr_en = 1'b1;
                wr_addr = slot_reg;
                wr_entry.valid = 1'b1;
                wr_entry.nice = '0;
                wr_entry.prio = mlfq_pkg::calc_prio(rd_entry.rcpu, 6'sd0);
                state_next = S_REP_RD;
            end
            S_REP_RD:
            begin
                rd_en = 1'b1;
                rd_addr = slot_reg;
                state_next = S_REP;
            end
            S_REP:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idle_slot_reg <= '0;
            load_reg      <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
                idle_slot_reg <= cfg_wr_data;
            if (state_reg == S_LOAD)
                load_reg <= load_next;
            if (state_reg == S_IDLE)
                idx_reg <= '0;
            else if ((state_reg == S_SW_WR) ||
                     (state_reg == S_SW_OP && func_reg != mlfq_pkg::FN_SECOND))
                idx_reg <= idx_reg + 6'd1;
            if (state_reg == S_REP && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            func_reg    <= func;
            slot_reg    <= slot;
            run_reg     <= running_slot;
            ready_reg   <= ready_count;
            nice_in_reg <= nice_value;
        end
        if (div_done)
            coef_reg <= div_quot;
        if (state_reg == S_SW_OP)
            prod_reg <= $signed({1'b0, coef_reg}) * rd_entry.rcpu;
        if (state_reg == S_REP && (!out_valid_reg || !out_stall))
        begin
            slot_valid      <= rd_entry.valid;
            slot_priority   <= rd_entry.prio;
            slot_nice       <= rd_entry.nice;
            recent_cpu_x100 <= rc100[38] ? -$signed(rc_round) : $signed(rc_round);
            load_avg_x100   <= (ld_round > 28'd8191) ? 13'd8191 : ld_round[12:0];
        end
    end

`ifndef ASSERT_OFF
    // a waiting result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REP && out_valid && out_stall) |=> state_reg == S_REP)
        else $error("result overwritten while stalled");

    // divider only finishes inside a second update
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider done outside second update");

    // sweep index only moves in the sweep or returns to zero from idle
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(idx_reg) |-> ($past(state_reg) == S_SW_OP ||
                               $past(state_reg) == S_SW_WR ||
                               $past(state_reg) == S_IDLE))
        else $error("sweep index moved outside sweep");
`endif

endmodule

// ===== hdl/mlfq_div.sv =====
// ============================================================================
// mlfq_div
// Restoring divider for the recent-cpu decay coefficient, one bit a cycle.
// ============================================================================
module mlfq_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [mlfq_pkg::NUM_W-1:0]         num,
    input  logic [mlfq_pkg::DEN_W-1:0]         den,
    output logic                               done,
    output logic [mlfq_pkg::COEF_W-1:0]        quot
);

    logic [mlfq_pkg::NUM_W-1:0]  rem_reg;
    logic [mlfq_pkg::NUM_W-1:0]  dsh_reg;
    logic [mlfq_pkg::COEF_W-1:0] q_reg;
    logic [4:0]                  cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic                        ge;

    assign ge   = rem_reg >= dsh_reg;
    assign done = done_reg;
    assign quot = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(mlfq_pkg::COEF_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            dsh_reg <= mlfq_pkg::NUM_W'(den) << (mlfq_pkg::COEF_W - 1);
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
                rem_reg <= rem_reg - dsh_reg;
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= {q_reg[mlfq_pkg::COEF_W-2:0], ge};
        end
    end

endmodule

// ===== hdl/mlfq_slot_store.sv =====
// ============================================================================
// mlfq_slot_store
// Slot table memory with per-slot live bits; dead slots read as reset values.
// ============================================================================
module mlfq_slot_store (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               rd_en,
    input  logic [mlfq_pkg::SLOT_W-1:0]        rd_addr,
    output mlfq_pkg::slot_entry_t              rd_entry,
    input  logic                               wr_en,
    input  logic [mlfq_pkg::SLOT_W-1:0]        wr_addr,
    input  mlfq_pkg::slot_entry_t              wr_entry
);

    logic [43:0]                    mem [mlfq_pkg::NUM_SLOTS];
    logic [mlfq_pkg::NUM_SLOTS-1:0] live_reg;
    logic [43:0]                    rd_data_reg;
    logic                           rd_live_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= {wr_entry.nice, wr_entry.rcpu, wr_entry.prio};
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg    <= '0;
            rd_live_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                live_reg[wr_addr] <= wr_entry.valid;
            if (rd_en)
                rd_live_reg <= live_reg[rd_addr];
        end
    end

    always_comb
    begin
        if (rd_live_reg)
        begin
            rd_entry.valid = 1'b1;
            rd_entry.nice  = rd_data_reg[43:38];
            rd_entry.rcpu  = rd_data_reg[37:6];
            rd_entry.prio  = rd_data_reg[5:0];
        end
        else
        begin
            rd_entry.valid = 1'b0;
            rd_entry.nice  = '0;
            rd_entry.rcpu  = '0;
            rd_entry.prio  = 6'(mlfq_pkg::PRIO_MAX);
        end
    end

endmodule
